>>> rtl/core/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// Key debounce package
// Types, codes and defaults shared by the key debounce and long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  localparam int unsigned KEYS_DEFAULT = 4;
  localparam int unsigned KEYS_MAX     = 8;
  localparam int unsigned RAW_W        = 4;
  localparam int unsigned MASK_W       = 4;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned DEB_W        = 8;
  localparam int unsigned LONG_W       = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd20;
  localparam logic [LONG_W-1:0] LONG_PRESS_RESET = 16'd800;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

  localparam logic [1:0] MODE_SCAN = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] PH_IDLE        = 2'd0;
  localparam logic [1:0] PH_DEB_PRESS   = 2'd1;
  localparam logic [1:0] PH_PRESSED     = 2'd2;
  localparam logic [1:0] PH_DEB_RELEASE = 2'd3;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_LONG     = 2'd2;
  localparam logic [1:0] EV_RELEASED = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [RAW_W-1:0]  raw_levels;
    logic [TIME_W-1:0] now_ms;
    logic [IDX_W-1:0]  key_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        event_code;
    logic              key_down;
    logic [MASK_W-1:0] down_mask;
  } rsp_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ms;
    logic [LONG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic       down_next;
    logic [1:0] pending;
  } lane_status_t;

endpackage

>>> rtl/core/kdlp_lane.sv
// ----------------------------------------------------------------------------
// Key debounce lane
// State machine and pending event store of one key.
// ----------------------------------------------------------------------------
module kdlp_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             scan,
  input  logic                             read_clear,
  input  logic                             raw,
  input  logic [kdlp_pkg::TIME_W-1:0]      now_ms,
  input  kdlp_pkg::cfg_t                   cfg,
  output kdlp_pkg::lane_status_t           status
);

  logic [1:0]                    phase;
  logic [1:0]                    phase_next;
  logic                          stable_down;
  logic                          stable_down_next;
  logic                          long_reported;
  logic                          long_reported_next;
  logic [1:0]                    pending;
  logic [1:0]                    pending_next;
  logic [kdlp_pkg::TIME_W-1:0]   phase_start;
  logic [kdlp_pkg::TIME_W-1:0]   phase_start_next;
  logic [kdlp_pkg::TIME_W-1:0]   press_start;
  logic [kdlp_pkg::TIME_W-1:0]   press_start_next;
  logic [kdlp_pkg::TIME_W-1:0]   phase_elapsed;
  logic [kdlp_pkg::TIME_W-1:0]   press_elapsed;
  logic                          deb_done;
  logic                          long_done;

  assign phase_elapsed = now_ms - phase_start;
  assign press_elapsed = now_ms - press_start;
  assign deb_done  = phase_elapsed >= {{(kdlp_pkg::TIME_W-kdlp_pkg::DEB_W){1'b0}},
                                       cfg.debounce_ms};
  assign long_done = press_elapsed >= {{(kdlp_pkg::TIME_W-kdlp_pkg::LONG_W){1'b0}},
                                       cfg.long_press_ms};

  always_comb begin
    phase_next         = phase;
    stable_down_next   = stable_down;
    long_reported_next = long_reported;
    pending_next       = pending;
    phase_start_next   = phase_start;
    press_start_next   = press_start;
    if (read_clear) begin
      pending_next = kdlp_pkg::EV_NONE;
    end
    if (scan) begin
      case (phase)
        kdlp_pkg::PH_IDLE: begin
          if (raw) begin
            phase_next       = kdlp_pkg::PH_DEB_PRESS;
            phase_start_next = now_ms;
          end
        end
        kdlp_pkg::PH_DEB_PRESS: begin
          if (!raw) begin
            phase_next = kdlp_pkg::PH_IDLE;
          end else if (deb_done) begin
            phase_next         = kdlp_pkg::PH_PRESSED;
            stable_down_next   = 1'b1;
            press_start_next   = now_ms;
            long_reported_next = 1'b0;
            pending_next       = kdlp_pkg::EV_PRESSED;
          end
        end
        kdlp_pkg::PH_PRESSED: begin
          if (!raw) begin
            phase_next       = kdlp_pkg::PH_DEB_RELEASE;
            phase_start_next = now_ms;
          end else if (!long_reported && long_done) begin
            long_reported_next = 1'b1;
            pending_next       = kdlp_pkg::EV_LONG;
          end
        end
        default: begin
          if (raw) begin
            phase_next = kdlp_pkg::PH_PRESSED;
          end else if (deb_done) begin
            phase_next       = kdlp_pkg::PH_IDLE;
            stable_down_next = 1'b0;
            pending_next     = kdlp_pkg::EV_RELEASED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= kdlp_pkg::PH_IDLE;
      stable_down   <= 1'b0;
      long_reported <= 1'b0;
      pending       <= kdlp_pkg::EV_NONE;
    end else if (accept) begin
      phase         <= phase_next;
      stable_down   <= stable_down_next;
      long_reported <= long_reported_next;
      pending       <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phase_start <= phase_start_next;
      press_start <= press_start_next;
    end
  end

  assign status.down_next = stable_down_next;
  assign status.pending   = pending;

endmodule

>>> rtl/core/kdlp_merge.sv
// ----------------------------------------------------------------------------
// Key debounce merge stage
// Selects the addressed key, gathers the down mask and holds the result.
// ----------------------------------------------------------------------------
module kdlp_merge #(
  parameter int unsigned KEYS = kdlp_pkg::KEYS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  kdlp_pkg::req_t         req,
  input  kdlp_pkg::lane_status_t lane_status [KEYS],
  input  logic                   rsp_stall,
  output logic                   rsp_valid,
  output kdlp_pkg::rsp_t         rsp
);

  localparam int unsigned MASK_KEYS = (KEYS < kdlp_pkg::MASK_W) ? KEYS : kdlp_pkg::MASK_W;

  kdlp_pkg::rsp_t rsp_next;
  logic [1:0]     sel_event;

  always_comb begin
    sel_event = kdlp_pkg::EV_NONE;
    rsp_next  = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (req.key_index == kdlp_pkg::IDX_W'(k)) begin
        sel_event         = lane_status[k].pending;
        rsp_next.key_down = lane_status[k].down_next;
      end
    end
    for (int k = 0; k < MASK_KEYS; k++) begin
      rsp_next.down_mask[k] = lane_status[k].down_next;
    end
    if (req.mode == kdlp_pkg::MODE_READ) begin
      rsp_next.event_code = sel_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/core/key_debounce_long_press_unit.sv
// ----------------------------------------------------------------------------
// Key debounce with long-press detection
// Debounces up to four keys and reports press, long-press and release events.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req) carries one transaction per
// item: a scan with the raw key levels and a millisecond timestamp, a read
// that returns and clears a key's pending event, or a peek at a key's stable
// down flag. The response channel (rsp_valid, rsp_stall, rsp) returns exactly
// one transaction per request, in order.
// Every key has its own lane, and all lanes update in the cycle the request
// is taken, so the block takes one request every cycle unless stalled. It
// registers the response in the cycle after acceptance. While a response is
// stalled the block holds it and stalls the request channel; as soon as the
// response is taken a new request can enter in the same cycle.
// Synchronous reset returns every key to idle with no pending event and
// restores the debounce and long-press times to 20 ms and 800 ms.
// The register port (cfg_we, cfg_index, cfg_data) writes register 0, the
// debounce time, and register 1, the long-press time; other indices are
// ignored. Writes are meant for times when no request is in flight.
// ----------------------------------------------------------------------------
module key_debounce_long_press_unit #(
  parameter int unsigned KEYS = kdlp_pkg::KEYS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  kdlp_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output kdlp_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  kdlp_pkg::cfg_t         cfg;
  kdlp_pkg::lane_status_t lane_status [KEYS];
  logic                   accept;
  logic                   scan;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign scan      = req.mode == kdlp_pkg::MODE_SCAN;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= kdlp_pkg::DEBOUNCE_RESET;
      cfg.long_press_ms <= kdlp_pkg::LONG_PRESS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == kdlp_pkg::REG_DEBOUNCE) begin
        cfg.debounce_ms <= cfg_data[kdlp_pkg::DEB_W-1:0];
      end else if (cfg_index == kdlp_pkg::REG_LONG_PRESS) begin
        cfg.long_press_ms <= cfg_data[kdlp_pkg::LONG_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    logic raw;
    logic read_clear;

    if (k < kdlp_pkg::RAW_W) begin : g_raw
      assign raw = req.raw_levels[k];
    end else begin : g_noraw
      assign raw = 1'b0;
    end

    assign read_clear = (req.mode == kdlp_pkg::MODE_READ) &&
                        (req.key_index == kdlp_pkg::IDX_W'(k));

    kdlp_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .accept     (accept),
      .scan       (scan),
      .read_clear (read_clear),
      .raw        (raw),
      .now_ms     (req.now_ms),
      .cfg        (cfg),
      .status     (lane_status[k])
    );
  end

  kdlp_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req),
    .lane_status (lane_status),
    .rsp_stall   (rsp_stall),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp)
  );

endmodule

>>> verif/tb_key_debounce_long_press_unit.sv
// ----------------------------------------------------------------------------
// Key debounce and long-press unit testbench
// Drives scan, read, peek and reserved requests into the unit and checks every
// response against a cycle-free predictor of the key state machines, or a
// fixed one for some directed rows. A short table of directed requests comes
// first, then random key activity with bounce and time jumps under several
// debounce and long-press settings, with idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_press_unit;

  localparam int unsigned KEY_COUNT     = kdlp_pkg::KEYS_DEFAULT;
  localparam logic [1:0]  MODE_RESERVED = 2'd3;
  localparam logic [kdlp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [kdlp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 225;
  localparam kdlp_pkg::rsp_t RSP_QUIET  = '0;

  typedef struct {
    kdlp_pkg::req_t stim;
    bit             typed;
    kdlp_pkg::rsp_t want;
  } plan_row_t;

  logic                            clk;
  logic                            rst;
  logic                            req_valid;
  logic                            req_stall;
  kdlp_pkg::req_t                  req;
  logic                            rsp_valid;
  logic                            rsp_stall;
  kdlp_pkg::rsp_t                  rsp;
  logic                            cfg_we;
  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [1:0]                  key_phase    [KEY_COUNT];
  logic                        key_stable   [KEY_COUNT];
  logic                        key_long_done[KEY_COUNT];
  logic [kdlp_pkg::TIME_W-1:0] key_phase_t0 [KEY_COUNT];
  logic [kdlp_pkg::TIME_W-1:0] key_press_t0 [KEY_COUNT];
  logic [1:0]                  key_event    [KEY_COUNT];
  logic [kdlp_pkg::DEB_W-1:0]  debounce_q;
  logic [kdlp_pkg::LONG_W-1:0] long_press_q;

  kdlp_pkg::rsp_t expected_rsp_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic [kdlp_pkg::TIME_W-1:0] clock_ms;
  logic [kdlp_pkg::RAW_W-1:0]  held_keys;
  int unsigned                 step_max;

  key_debounce_long_press_unit #(
    .KEYS(KEY_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = ~clk;
    end
  end

  function automatic void reset_keys();
    debounce_q   = kdlp_pkg::DEBOUNCE_RESET;
    long_press_q = kdlp_pkg::LONG_PRESS_RESET;
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_phase[k]     = kdlp_pkg::PH_IDLE;
      key_stable[k]    = 1'b0;
      key_long_done[k] = 1'b0;
      key_phase_t0[k]  = '0;
      key_press_t0[k]  = '0;
      key_event[k]     = kdlp_pkg::EV_NONE;
    end
  endfunction

  function automatic kdlp_pkg::rsp_t predict_rsp(kdlp_pkg::req_t r);
    kdlp_pkg::rsp_t o;
    logic           raw;
    logic [31:0]    since_phase;
    logic [31:0]    since_press;
    bit             idx_ok;
    o = '0;
    idx_ok = r.key_index < KEY_COUNT;
    if (r.mode == kdlp_pkg::MODE_SCAN) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        raw = (k < kdlp_pkg::RAW_W) ? r.raw_levels[k] : 1'b0;
        since_phase = r.now_ms - key_phase_t0[k];
        since_press = r.now_ms - key_press_t0[k];
        case (key_phase[k])
          kdlp_pkg::PH_IDLE: begin
            if (raw) begin
              key_phase[k]    = kdlp_pkg::PH_DEB_PRESS;
              key_phase_t0[k] = r.now_ms;
            end
          end
          kdlp_pkg::PH_DEB_PRESS: begin
            if (!raw) begin
              key_phase[k] = kdlp_pkg::PH_IDLE;
            end else if (since_phase >= 32'(debounce_q)) begin
              key_phase[k]     = kdlp_pkg::PH_PRESSED;
              key_stable[k]    = 1'b1;
              key_press_t0[k]  = r.now_ms;
              key_long_done[k] = 1'b0;
              key_event[k]     = kdlp_pkg::EV_PRESSED;
            end
          end
          kdlp_pkg::PH_PRESSED: begin
            if (!raw) begin
              key_phase[k]    = kdlp_pkg::PH_DEB_RELEASE;
              key_phase_t0[k] = r.now_ms;
            end else if (!key_long_done[k] && since_press >= 32'(long_press_q)) begin
              key_long_done[k] = 1'b1;
              key_event[k]     = kdlp_pkg::EV_LONG;
            end
          end
          default: begin
            if (raw) begin
              key_phase[k] = kdlp_pkg::PH_PRESSED;
            end else if (since_phase >= 32'(debounce_q)) begin
              key_phase[k]  = kdlp_pkg::PH_IDLE;
              key_stable[k] = 1'b0;
              key_event[k]  = kdlp_pkg::EV_RELEASED;
            end
          end
        endcase
      end
    end else if (r.mode == kdlp_pkg::MODE_READ && idx_ok) begin
      o.event_code = key_event[r.key_index];
      key_event[r.key_index] = kdlp_pkg::EV_NONE;
    end
    for (int k = 0; k < KEY_COUNT && k < kdlp_pkg::MASK_W; k++) begin
      o.down_mask[k] = key_stable[k];
    end
    o.key_down = idx_ok ? key_stable[r.key_index] : 1'b0;
    return o;
  endfunction

  function automatic plan_row_t row(logic [1:0] mode,
                                    logic [kdlp_pkg::RAW_W-1:0] raw,
                                    logic [kdlp_pkg::TIME_W-1:0] now,
                                    logic [kdlp_pkg::IDX_W-1:0] idx,
                                    bit typed, kdlp_pkg::rsp_t want);
    plan_row_t p;
    p.stim.mode       = mode;
    p.stim.raw_levels = raw;
    p.stim.now_ms     = now;
    p.stim.key_index  = idx;
    p.typed           = typed;
    p.want            = want;
    return p;
  endfunction

  function automatic kdlp_pkg::req_t next_item();
    kdlp_pkg::req_t r;
    int unsigned    pick;
    r.mode       = kdlp_pkg::MODE_SCAN;
    r.raw_levels = kdlp_pkg::RAW_W'($urandom);
    r.now_ms     = $urandom;
    r.key_index  = ($urandom_range(9) == 0) ? kdlp_pkg::IDX_W'($urandom_range(7, 4))
                                            : kdlp_pkg::IDX_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 68) begin
      if ($urandom_range(19) == 0) begin
        held_keys[$urandom_range(kdlp_pkg::RAW_W - 1)] ^= 1'b1;
      end
      if ($urandom_range(39) == 0) begin
        clock_ms = $urandom;
      end else begin
        clock_ms += $urandom_range(step_max);
      end
      r.raw_levels = held_keys;
      for (int k = 0; k < kdlp_pkg::RAW_W; k++) begin
        if ($urandom_range(11) == 0) begin
          r.raw_levels[k] = ~r.raw_levels[k];
        end
      end
      r.now_ms = clock_ms;
    end else if (pick < 88) begin
      r.mode = kdlp_pkg::MODE_READ;
    end else if (pick < 97) begin
      r.mode = kdlp_pkg::MODE_PEEK;
    end else begin
      r.mode = MODE_RESERVED;
    end
    return r;
  endfunction

  task automatic issue(input kdlp_pkg::req_t r, input bit typed, input kdlp_pkg::rsp_t want);
    int unsigned    gap;
    kdlp_pkg::rsp_t got;
    gap = 0;
    while (gap < 6 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    got = predict_rsp(r);
    expected_rsp_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdlp_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    if (idx == kdlp_pkg::REG_DEBOUNCE) begin
      debounce_q = data[kdlp_pkg::DEB_W-1:0];
    end else if (idx == kdlp_pkg::REG_LONG_PRESS) begin
      long_press_q = data[kdlp_pkg::LONG_W-1:0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("response mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin : rsp_check
    kdlp_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("response transaction with nothing expected: %h", rsp);
        end
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.event_code !== want.event_code) begin
          note_mismatch("event_code", 32'(want.event_code), 32'(rsp.event_code));
        end
        if (rsp.key_down !== want.key_down) begin
          note_mismatch("key_down", 32'(want.key_down), 32'(rsp.key_down));
        end
        if (rsp.down_mask !== want.down_mask) begin
          note_mismatch("down_mask", 32'(want.down_mask), 32'(rsp.down_mask));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_debounce_long_press_unit test failed");
      $finish;
    end
  end

  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    plan_row_t                   plan[$];
    logic [kdlp_pkg::DEB_W-1:0]  deb;
    logic [kdlp_pkg::LONG_W-1:0] lng;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_keys();
    held_keys = '0;
    clock_ms  = '0;
    step_max  = 1;

    plan.push_back(row(kdlp_pkg::MODE_PEEK, 4'h0, 32'd0,         3'd0, 1'b1, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd0, 1'b1, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'hF, 32'hFFFF_FFFF, 3'd7, 1'b1, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h1, 32'd100,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h1, 32'd119,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h1, 32'd120,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h1, 32'd919,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h1, 32'd920,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h0, 32'd930,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h1, 32'd935,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h0, 32'd940,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h0, 32'd960,       3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(MODE_RESERVED,       4'hA, 32'h5555_AAAA, 3'd1, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_PEEK, 4'h5, 32'hAAAA_5555, 3'd4, 1'b1, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'hF, 32'hFFFF_FFF0, 3'd2, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'hF, 32'h0000_0004, 3'd2, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_PEEK, 4'h0, 32'd0,         3'd3, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd1, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h0, 32'd5,         3'd0, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_SCAN, 4'h0, 32'd25,        3'd3, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd3, 1'b0, RSP_QUIET));
    plan.push_back(row(kdlp_pkg::MODE_READ, 4'h0, 32'd0,         3'd6, 1'b1, RSP_QUIET));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 34;
    recv_stall_pct = 54;
    foreach (plan[i]) begin
      issue(plan[i].stim, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin deb = kdlp_pkg::DEBOUNCE_RESET; lng = kdlp_pkg::LONG_PRESS_RESET; end
        1: begin deb = '0;                       lng = '0;                         end
        2: begin deb = '1;                       lng = '1;                         end
        3: begin
          deb = kdlp_pkg::DEB_W'($urandom_range(40, 1));
          lng = kdlp_pkg::LONG_W'($urandom_range(600, 20));
        end
        4: begin deb = 8'd3;                     lng = 16'd1;                      end
        default: begin
          deb = kdlp_pkg::DEB_W'($urandom_range(255));
          lng = kdlp_pkg::LONG_W'($urandom_range(2000));
        end
      endcase
      write_reg(kdlp_pkg::REG_DEBOUNCE, {8'($urandom_range(255)), deb});
      write_reg(kdlp_pkg::REG_LONG_PRESS, lng);
      if (p == 0 || p == 5) begin
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'($urandom));
      end
      send_idle_pct  = (p < 2) ? 34 : (p < 4) ? 54 : 0;
      recv_stall_pct = (p < 2) ? 54 : (p < 4) ? 34 : 0;
      clock_ms  = $urandom;
      held_keys = '0;
      step_max  = 1 + (int'(deb) + int'(lng) / 16) / 4;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 1 || p == 4) && n == 60) begin
          hold_left = 300;
        end
        if (p == 5 && n == 110) begin
          drain();
        end
        issue(next_item(), 1'b0, RSP_QUIET);
      end
    end

    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("key_debounce_long_press_unit test passed");
    end else begin
      $display("key_debounce_long_press_unit test failed");
    end
    $finish;
  end

endmodule
